// File: hw/rtl/tcce_pkg.sv
// Shared constants, opcodes and helpers for the text console character engine.
// No dependencies.
package tcce_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;
    // cells kept by a scroll: every row but the last
    localparam int KEEP    = (ROWS - 1) * COLUMNS;

    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int LOC_W   = 11;
    localparam int CELL_W  = 16;
    localparam int ATTR_W  = 8;
    localparam int CHAR_W  = 8;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int CNT_W   = $clog2(CELLS + 1);

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_CLEAR = 2'd1,
        OP_SET   = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LAST  = 8'h7F;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] col,
                                                    input logic [ROW_W-1:0] row);
        return ADDR_W'(32'(row) * COLUMNS + 32'(col));
    endfunction

    function automatic logic [LOC_W-1:0] cell_loc(input logic [COL_W-1:0] col,
                                                  input logic [ROW_W-1:0] row);
        return LOC_W'(32'(row) * COLUMNS + 32'(col));
    endfunction

endpackage

// File: hw/rtl/text_console_char_engine_top.sv
// Text console character engine: cursor control and screen cell store.
// Depends on tcce_pkg and tcce_ram.
//
// Usage:
//  - Command channel: drive opcode, char_code, target_col, target_row and raise
//    start; the transfer happens on a rising edge with start high and busy low.
//  - Result channel: done pulses for one cycle with cursor_col, cursor_row,
//    cursor_offset and cell_value. Every command gives exactly one result.
//    The receiver cannot stall; the result must be taken in that cycle.
//  - text_attribute_we / text_attribute_wdata write the attribute byte used
//    for written and blank cells; write it only while the block is idle.
//  - From start to done: S_EXEC for set position and characters that do not
//    scroll; S_EXEC, S_READ for read cell; S_EXEC, S_CLEAR for clear screen;
//    S_EXEC, S_SCROLL for a character that scrolls; done is registered.
//    The screen store has one write and one read port, so clear and scroll
//    move one cell per cycle. One command is in flight at a time; a new start
//    can be taken in the cycle done is high.
//  - Reset puts the cursor at column 0, row 0 and the attribute at 0x0F. The
//    screen contents are unknown until a clear screen command.
module text_console_char_engine_top
    import tcce_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        opcode,
    input  logic [CHAR_W-1:0] char_code,
    input  logic [COL_W-1:0]  target_col,
    input  logic [ROW_W-1:0]  target_row,
    input  logic              text_attribute_we,
    input  logic [ATTR_W-1:0] text_attribute_wdata,
    output logic              done,
    output logic [COL_W-1:0]  cursor_col,
    output logic [ROW_W-1:0]  cursor_row,
    output logic [LOC_W-1:0]  cursor_offset,
    output logic [CELL_W-1:0] cell_value
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SCROLL,
        S_CLEAR
    } state_t;

    state_t             state_reg, state_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [ATTR_W-1:0]  attr_reg;

    op_t                op_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic [COL_W-1:0]   tcol_reg;
    logic [ROW_W-1:0]   trow_reg;

    logic               done_reg;
    logic [COL_W-1:0]   out_col_reg;
    logic [ROW_W-1:0]   out_row_reg;
    logic [LOC_W-1:0]   out_loc_reg;
    logic [CELL_W-1:0]  out_cell_reg;

    logic               fin;
    logic [CELL_W-1:0]  cell_next;
    logic [COL_W:0]     col_ext;
    logic               line_inc;
    logic               target_ok;
    logic [CELL_W-1:0]  blank;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [CELL_W-1:0]  mem_wdata;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [CELL_W-1:0]  mem_rdata;

    tcce_ram #(
        .WIDTH(CELL_W),
        .DEPTH(CELLS)
    ) u_screen (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    assign blank     = {attr_reg, CH_SPACE};
    assign target_ok = ({1'b0, tcol_reg} < (COL_W + 1)'(COLUMNS))
                    && ({1'b0, trow_reg} < (ROW_W + 1)'(ROWS));

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        cnt_next   = cnt_reg;
        fin        = 1'b0;
        cell_next  = '0;
        col_ext    = {1'b0, col_reg};
        line_inc   = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = blank;
        mem_raddr  = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                case (op_reg)
                    OP_WRITE:
                    begin
                        if (char_reg == CH_BS)
                        begin
                            if (col_reg != '0)
                            begin
                                col_ext   = col_ext - (COL_W + 1)'(1);
                                mem_we    = 1'b1;
                                mem_waddr = cell_addr(col_reg - COL_W'(1), row_reg);
                                mem_wdata = blank;
                            end
                        end
                        else if (char_reg == CH_TAB)
                        begin
                            col_ext = (col_ext + (COL_W + 1)'(8)) & ~(COL_W + 1)'(7);
                        end
                        else if (char_reg == CH_CR)
                        begin
                            col_ext = '0;
                        end
                        else if (char_reg == CH_LF)
                        begin
                            col_ext  = '0;
                            line_inc = 1'b1;
                        end
                        else if (char_reg inside {[CH_SPACE:CH_LAST]})
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = cell_addr(col_reg, row_reg);
                            mem_wdata = {attr_reg, char_reg};
                            col_ext   = col_ext + (COL_W + 1)'(1);
                        end

                        // line overflow wraps
                        if (col_ext >= (COL_W + 1)'(COLUMNS))
                        begin
                            col_ext  = '0;
                            line_inc = 1'b1;
                        end
                        col_next = col_ext[COL_W-1:0];

                        if (line_inc && row_reg == ROW_W'(ROWS - 1))
                        begin
                            cnt_next   = '0;
                            state_next = S_SCROLL;
                        end
                        else
                        begin
                            if (line_inc)
                            begin
                                row_next = row_reg + ROW_W'(1);
                            end
                            fin        = 1'b1;
                            state_next = S_IDLE;
                        end
                    end

                    OP_CLEAR:
                    begin
                        col_next   = '0;
                        row_next   = '0;
                        cnt_next   = '0;
                        state_next = S_CLEAR;
                    end

                    OP_SET:
                    begin
                        if (target_ok)
                        begin
                            col_next = tcol_reg;
                            row_next = trow_reg;
                        end
                        fin        = 1'b1;
                        state_next = S_IDLE;
                    end

                    OP_READ:
                    begin
                        if (target_ok)
                        begin
                            mem_raddr = cell_addr(tcol_reg, trow_reg);
                        end
                        state_next = S_READ;
                    end

                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_READ:
            begin
                cell_next  = target_ok ? mem_rdata : '0;
                fin        = 1'b1;
                state_next = S_IDLE;
            end

            S_SCROLL:
            begin
                // read one row ahead, write the cell fetched last cycle one behind
                if (32'(cnt_reg) + COLUMNS < CELLS)
                begin
                    mem_raddr = ADDR_W'(32'(cnt_reg) + COLUMNS);
                end
                if (cnt_reg != '0)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ADDR_W'(cnt_reg - CNT_W'(1));
                    mem_wdata = (32'(cnt_reg) <= KEEP) ? mem_rdata : blank;
                end
                if (cnt_reg == CNT_W'(CELLS))
                begin
                    fin        = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(cnt_reg);
                mem_wdata = blank;
                if (cnt_reg == CNT_W'(CELLS - 1))
                begin
                    fin        = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            col_reg      <= '0;
            row_reg      <= '0;
            cnt_reg      <= '0;
            attr_reg     <= ATTR_RESET;
            done_reg     <= 1'b0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_loc_reg  <= '0;
            out_cell_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            cnt_reg   <= cnt_next;
            done_reg  <= fin;
            if (text_attribute_we)
            begin
                attr_reg <= text_attribute_wdata;
            end
            if (fin)
            begin
                out_col_reg  <= col_next;
                out_row_reg  <= row_next;
                out_loc_reg  <= cell_loc(col_next, row_next);
                out_cell_reg <= cell_next;
            end
        end
    end

    // command latch
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            op_reg   <= op_t'(opcode);
            char_reg <= char_code;
            tcol_reg <= target_col;
            trow_reg <= target_row;
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign cursor_col    = out_col_reg;
    assign cursor_row    = out_row_reg;
    assign cursor_offset = out_loc_reg;
    assign cell_value    = out_cell_reg;

endmodule

// File: hw/rtl/tcce_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sim/tcce_result_check.sv
// Result checker for text_console_char_engine_top: keeps its own cursor, attribute
// and screen image, predicts the result of every accepted command and compares it.
// Depends on tcce_pkg.
module tcce_result_check
    import tcce_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [1:0]        opcode,
    input  logic [CHAR_W-1:0] char_code,
    input  logic [COL_W-1:0]  target_col,
    input  logic [ROW_W-1:0]  target_row,
    input  logic              text_attribute_we,
    input  logic [ATTR_W-1:0] text_attribute_wdata,
    input  logic              done,
    input  logic [COL_W-1:0]  cursor_col,
    input  logic [ROW_W-1:0]  cursor_row,
    input  logic [LOC_W-1:0]  cursor_offset,
    input  logic [CELL_W-1:0] cell_value,
    output int                fail_count,
    output int                pending
);

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [LOC_W-1:0]  loc;
        logic [CELL_W-1:0] data;
    } cursor_report_t;

    logic [CELL_W-1:0] screen [CELLS];
    int                col_now;
    int                row_now;
    logic [ATTR_W-1:0] attr;
    cursor_report_t    reports_due [$];

    function automatic logic [CELL_W-1:0] space_cell();
        return {attr, CH_SPACE};
    endfunction

    function automatic void scroll_up();
        for (int i = 0; i < KEEP; i++)
            screen[i] = screen[i + COLUMNS];
        for (int i = KEEP; i < CELLS; i++)
            screen[i] = space_cell();
        row_now = ROWS - 1;
    endfunction

    function automatic void type_char(logic [CHAR_W-1:0] ch);
        if (ch == CH_BS && col_now != 0)
        begin
            col_now--;
            screen[row_now * COLUMNS + col_now] = space_cell();
        end
        else if (ch == CH_TAB)
            col_now = (col_now + 8) & ~7;
        else if (ch == CH_CR)
            col_now = 0;
        else if (ch == CH_LF)
        begin
            col_now = 0;
            row_now++;
        end
        else if (ch >= CH_SPACE && ch <= CH_LAST)
        begin
            screen[row_now * COLUMNS + col_now] = {attr, ch};
            col_now++;
        end
        // backspace at column 0 and unprintable bytes fall through untouched
        if (col_now >= COLUMNS)
        begin
            col_now = 0;
            row_now++;
        end
        if (row_now >= ROWS)
            scroll_up();
    endfunction

    function automatic cursor_report_t run_command(op_t op, logic [CHAR_W-1:0] ch,
                                                   logic [COL_W-1:0] tcol,
                                                   logic [ROW_W-1:0] trow);
        cursor_report_t r;
        logic [CELL_W-1:0] got;
        got = '0;
        case (op)
            OP_WRITE: type_char(ch);
            OP_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                    screen[i] = space_cell();
                col_now = 0;
                row_now = 0;
            end
            OP_SET:
            begin
                if (tcol < COLUMNS && trow < ROWS)
                begin
                    col_now = tcol;
                    row_now = trow;
                end
            end
            default:
            begin
                if (tcol < COLUMNS && trow < ROWS)
                    got = screen[trow * COLUMNS + tcol];
            end
        endcase
        r.col  = COL_W'(col_now);
        r.row  = ROW_W'(row_now);
        r.loc  = LOC_W'(row_now * COLUMNS + col_now);
        r.data = got;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cursor_report_t want;
        if (!rst_n)
        begin
            col_now = 0;
            row_now = 0;
            attr = ATTR_RESET;
            reports_due.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (done)
            begin
                if (reports_due.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("result with no command outstanding: col %0d row %0d",
                                 cursor_col, cursor_row);
                    fail_count++;
                end
                else
                begin
                    want = reports_due.pop_front();
                    if (cursor_col !== want.col || cursor_row !== want.row ||
                        cursor_offset !== want.loc || cell_value !== want.data)
                    begin
                        if (fail_count < 10)
                            $display({"mismatch: expected col %0d row %0d loc %0d cell %h,",
                                      " got col %0d row %0d loc %0d cell %h"},
                                     want.col, want.row, want.loc, want.data,
                                     cursor_col, cursor_row, cursor_offset, cell_value);
                        fail_count++;
                    end
                end
            end
            if (text_attribute_we)
                attr = text_attribute_wdata;
            if (start && !busy)
                reports_due.push_back(run_command(op_t'(opcode), char_code,
                                                  target_col, target_row));
            pending = reports_due.size();
        end
    end

endmodule

// File: sim/tb.sv
// Testbench top for text_console_char_engine_top: clock, reset, command stimulus
// and attribute writes; prediction and comparison live in tcce_result_check.
// Depends on tcce_pkg, the block and tcce_result_check.
module tb;
    import tcce_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    op_t               opcode;
    logic [CHAR_W-1:0] char_code;
    logic [COL_W-1:0]  target_col;
    logic [ROW_W-1:0]  target_row;
    logic              text_attribute_we;
    logic [ATTR_W-1:0] text_attribute_wdata;
    logic              done;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [LOC_W-1:0]  cursor_offset;
    logic [CELL_W-1:0] cell_value;
    int                fail_count;
    int                pending;
    int                cycles = 0;
    bit                gaps_on;

    text_console_char_engine_top i_dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .start                (start),
        .busy                 (busy),
        .opcode               (opcode),
        .char_code            (char_code),
        .target_col           (target_col),
        .target_row           (target_row),
        .text_attribute_we    (text_attribute_we),
        .text_attribute_wdata (text_attribute_wdata),
        .done                 (done),
        .cursor_col           (cursor_col),
        .cursor_row           (cursor_row),
        .cursor_offset        (cursor_offset),
        .cell_value           (cell_value)
    );

    tcce_result_check i_result_check (
        .clk                  (clk),
        .rst_n                (rst_n),
        .start                (start),
        .busy                 (busy),
        .opcode               (opcode),
        .char_code            (char_code),
        .target_col           (target_col),
        .target_row           (target_row),
        .text_attribute_we    (text_attribute_we),
        .text_attribute_wdata (text_attribute_wdata),
        .done                 (done),
        .cursor_col           (cursor_col),
        .cursor_row           (cursor_row),
        .cursor_offset        (cursor_offset),
        .cell_value           (cell_value),
        .fail_count           (fail_count),
        .pending              (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // one command transfer; start stays high into the next unless a gap drops it
    task automatic send(op_t op, logic [CHAR_W-1:0] ch, logic [COL_W-1:0] tcol,
                        logic [ROW_W-1:0] trow);
        @(negedge clk);
        while (gaps_on && $urandom_range(0, 99) < 9)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start      <= 1'b1;
        opcode     <= op;
        char_code  <= ch;
        target_col <= tcol;
        target_row <= trow;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_attribute(logic [ATTR_W-1:0] value);
        text_attribute_we    <= 1'b1;
        text_attribute_wdata <= value;
        @(negedge clk);
        text_attribute_we    <= 1'b0;
    endtask

    // mostly text with line control, cursor moves biased toward the right edge
    // and bottom rows so wraps and scrolls are frequent
    task automatic random_command();
        int unsigned       pick;
        int unsigned       kind;
        logic [CHAR_W-1:0] ch;
        logic [COL_W-1:0]  tcol;
        logic [ROW_W-1:0]  trow;
        pick = $urandom_range(0, 99);
        ch   = CHAR_W'($urandom_range(0, 255));
        tcol = COL_W'($urandom_range(0, 127));
        trow = ROW_W'($urandom_range(0, 31));
        if (pick < 3)
            send(OP_CLEAR, ch, tcol, trow);
        else if (pick < 58)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 7)
                ch = CHAR_W'($urandom_range(CH_SPACE, CH_LAST));
            else if (kind < 9)
            begin
                case ($urandom_range(0, 3))
                    0:       ch = CH_BS;
                    1:       ch = CH_TAB;
                    2:       ch = CH_CR;
                    default: ch = CH_LF;
                endcase
            end
            send(OP_WRITE, ch, tcol, trow);
        end
        else
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                tcol = COL_W'($urandom_range($urandom_range(0, 1) ? 60 : 0, COLUMNS - 1));
                trow = ROW_W'($urandom_range($urandom_range(0, 1) ? 20 : 0, ROWS - 1));
            end
            if (pick < 73)
                send(OP_SET, ch, tcol, trow);
            else
                send(OP_READ, ch, tcol, trow);
        end
    endtask

    initial
    begin
        rst_n                = 1'b0;
        start                = 1'b0;
        opcode               = OP_WRITE;
        char_code            = '0;
        target_col           = '0;
        target_row           = '0;
        text_attribute_we    = 1'b0;
        text_attribute_wdata = '0;
        gaps_on              = 1'b1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // screen is unknown until cleared, so clear comes first
        send(OP_CLEAR, 8'h00, 7'd0, 5'd0);
        send(OP_WRITE, 8'h41, 7'd0, 5'd0);
        send(OP_WRITE, CH_SPACE, 7'd0, 5'd0);
        send(OP_WRITE, CH_LAST, 7'd0, 5'd0);
        send(OP_WRITE, 8'h80, 7'd0, 5'd0);
        send(OP_WRITE, 8'hFF, 7'd0, 5'd0);
        send(OP_WRITE, 8'h00, 7'd0, 5'd0);
        send(OP_WRITE, 8'h1F, 7'd0, 5'd0);
        send(OP_WRITE, CH_BS, 7'd0, 5'd0);
        send(OP_READ, 8'h00, 7'd2, 5'd0);
        send(OP_WRITE, CH_TAB, 7'd0, 5'd0);
        send(OP_WRITE, CH_CR, 7'd0, 5'd0);
        send(OP_WRITE, CH_BS, 7'd0, 5'd0);
        send(OP_WRITE, CH_LF, 7'd0, 5'd0);
        send(OP_SET, 8'h00, 7'd79, 5'd24);
        send(OP_WRITE, 8'h5A, 7'd0, 5'd0);
        send(OP_READ, 8'h00, 7'd79, 5'd23);
        send(OP_SET, 8'h00, 7'd80, 5'd0);
        send(OP_SET, 8'h00, 7'd0, 5'd25);
        send(OP_SET, 8'hFF, 7'd127, 5'd31);
        send(OP_READ, 8'hFF, 7'd127, 5'd31);
        send(OP_READ, 8'h00, 7'd80, 5'd24);
        send(OP_SET, 8'h00, 7'd76, 5'd24);
        send(OP_WRITE, CH_TAB, 7'd0, 5'd0);
        send(OP_WRITE, CH_LF, 7'd0, 5'd0);

        drain();
        set_attribute(8'h00);
        repeat (100) random_command();

        // long stretch with the sender never idling
        drain();
        set_attribute(8'hFF);
        gaps_on = 1'b0;
        repeat (100) random_command();

        drain();
        set_attribute(ATTR_W'($urandom_range(1, 254)));
        gaps_on = 1'b1;
        repeat (50) random_command();
        drain();
        repeat (50) random_command();

        drain();
        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
